// ===== src/mts_pkg.sv =====
// Shared constants and types of the min-tracking stack.
package mts_pkg;

	// Width of the fill count field on the result word
	localparam int FILL_BITS = 9;

	// Operation selector carried on s_tuser
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// Result status carried on m_tuser
	typedef logic [1:0] status_t;

	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_OVERFLOW  = 2'd1;
	localparam status_t STAT_UNDERFLOW = 2'd2;

endpackage

// ===== src/min_tracking_stack_core.sv =====
// Min-tracking LIFO stack: entry memory, cached top entry and result queue.

// Last-in first-out stack of signed VALUE_BITS-bit values that also reports the
// smallest value held. Each input word is a push (s_tuser = 0, value in s_tdata)
// or a pop (s_tuser = 1). Each input word gives exactly one result word with the
// new top value, the current minimum, the fill count and an empty flag, plus a
// status on m_tuser: ok, overflow (push onto a full stack refused) or underflow
// (pop on an empty stack refused). A refused operation leaves the stack as it was.
// Top and minimum read 0 while the stack is empty. Entries live in one
// synchronous memory of STACK_DEPTH words, each word holding a value and the
// running minimum of that value and everything below it; the top entry is also
// cached in registers. A push, a refused operation or a pop that leaves the stack
// empty writes its result in the cycle it is accepted; any other pop first waits in
// the read-wait state, as the new top comes from the registered memory read port.
// Results go into a two-word output queue, so the block keeps accepting input
// words while a result waits on m_tready. No clearing pass is needed after
// reset: only entries below the fill count are ever read.
module min_tracking_stack_core #(
	parameter int STACK_DEPTH = 256,
	parameter int VALUE_BITS  = 32,
	localparam int IN_DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8,
	localparam int OUT_FIELD_BITS = 2 * VALUE_BITS + mts_pkg::FILL_BITS + 1,
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // push_value
	input  logic                     s_tuser,   // kind
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // top_value, min_value, fill_count, is_empty
	output mts_pkg::status_t         m_tuser    // status
);

	import mts_pkg::*;

	localparam int ADDR_BITS = $clog2(STACK_DEPTH);
	localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);

	// Sequencer states
	localparam logic S_IDLE   = 1'b0;
	localparam logic S_RDWAIT = 1'b1;

	logic                   state_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [VALUE_BITS-1:0]  top_val_q;
	logic [VALUE_BITS-1:0]  top_min_q;

	// Entry memory: {running minimum, value}
	logic [2*VALUE_BITS-1:0] mem [STACK_DEPTH];
	logic [2*VALUE_BITS-1:0] rd_data_q;
	logic [ADDR_BITS-1:0]    rd_addr;
	logic                    mem_wr;

	// Two-word result queue
	logic [OUT_DATA_BITS-1:0] rq_data_q [2];
	status_t                  rq_stat_q [2];
	logic                     rq_wr_ptr_q;
	logic                     rq_rd_ptr_q;
	logic [1:0]               rq_occ_q;

	logic                  s_accept;
	logic                  m_accept;
	logic                  in_pop;
	logic [VALUE_BITS-1:0] in_value;
	logic                  is_full;
	logic                  is_zero;
	logic [VALUE_BITS-1:0] push_min;

	logic                  res_wr;
	logic [VALUE_BITS-1:0] res_top;
	logic [VALUE_BITS-1:0] res_min;
	logic [CNT_BITS-1:0]   res_cnt;
	status_t               res_stat;
	logic                  res_empty;
	logic [OUT_DATA_BITS-1:0] res_word;

	logic                  cnt_inc;
	logic                  cnt_dec;
	logic                  go_rdwait;

	// Take a word only between operations and while the queue has room for its result.
	assign s_tready = (state_q == S_IDLE) && ((rq_occ_q != 2'd2) || m_tready);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = (rq_occ_q != 2'd0);
	assign m_accept = m_tvalid && m_tready;
	assign m_tdata  = rq_data_q[rq_rd_ptr_q];
	assign m_tuser  = rq_stat_q[rq_rd_ptr_q];

	assign in_pop   = (s_tuser == KIND_POP);
	assign in_value = s_tdata[VALUE_BITS-1:0];
	assign is_full  = (count_q == CNT_BITS'(STACK_DEPTH));
	assign is_zero  = (count_q == '0);

	// An equal value keeps the minimum below it.
	assign push_min = (!is_zero && !($signed(in_value) < $signed(top_min_q))) ?
		top_min_q : in_value;

	// New top after a pop that keeps entries is the entry two below the current count.
	assign rd_addr = ADDR_BITS'(count_q - CNT_BITS'(2));

	always_comb begin
		res_wr    = 1'b0;
		res_top   = top_val_q;
		res_min   = top_min_q;
		res_cnt   = count_q;
		res_stat  = STAT_OK;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		go_rdwait = 1'b0;
		mem_wr    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					if (!in_pop) begin
						res_wr = 1'b1;
						if (is_full) begin
							res_stat = STAT_OVERFLOW;
						end else begin
							res_top = in_value;
							res_min = push_min;
							res_cnt = count_q + CNT_BITS'(1);
							cnt_inc = 1'b1;
							mem_wr  = 1'b1;
						end
					end else if (is_zero) begin
						res_wr   = 1'b1;
						res_stat = STAT_UNDERFLOW;
					end else begin
						cnt_dec = 1'b1;
						res_cnt = count_q - CNT_BITS'(1);
						if (count_q == CNT_BITS'(1)) begin
							res_wr = 1'b1;
						end else begin
							go_rdwait = 1'b1;
						end
					end
				end
			end
			S_RDWAIT: begin
				res_wr  = 1'b1;
				res_top = rd_data_q[VALUE_BITS-1:0];
				res_min = rd_data_q[2*VALUE_BITS-1:VALUE_BITS];
			end
			default: begin
			end
		endcase
	end

	assign res_empty = (res_cnt == '0);
	assign res_word  = OUT_DATA_BITS'({res_empty, FILL_BITS'(res_cnt),
		res_empty ? {VALUE_BITS{1'b0}} : res_min,
		res_empty ? {VALUE_BITS{1'b0}} : res_top});

	// Control: state, fill count, queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rq_wr_ptr_q <= 1'b0;
			rq_rd_ptr_q <= 1'b0;
			rq_occ_q    <= 2'd0;
		end else begin
			state_q <= go_rdwait ? S_RDWAIT : S_IDLE;
			if (cnt_inc) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_BITS'(1);
			end
			if (res_wr) begin
				rq_wr_ptr_q <= ~rq_wr_ptr_q;
			end
			if (m_accept) begin
				rq_rd_ptr_q <= ~rq_rd_ptr_q;
			end
			if (res_wr && !m_accept) begin
				rq_occ_q <= rq_occ_q + 2'd1;
			end else if (!res_wr && m_accept) begin
				rq_occ_q <= rq_occ_q - 2'd1;
			end
		end
	end

	// Payload: cached top entry and queued results
	always_ff @(posedge clk) begin
		if (cnt_inc) begin
			top_val_q <= in_value;
			top_min_q <= push_min;
		end else if (state_q == S_RDWAIT) begin
			top_val_q <= rd_data_q[VALUE_BITS-1:0];
			top_min_q <= rd_data_q[2*VALUE_BITS-1:VALUE_BITS];
		end
		if (res_wr) begin
			rq_data_q[rq_wr_ptr_q] <= res_word;
			rq_stat_q[rq_wr_ptr_q] <= res_stat;
		end
	end

	// Entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[count_q[ADDR_BITS-1:0]] <= {push_min, in_value};
		end
		rd_data_q <= mem[rd_addr];
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(STACK_DEPTH))
		else $error("fill count beyond stack depth");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_occ_q <= 2'd2)
		else $error("result queue overrun");

	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_pop && (count_q > CNT_BITS'(1))) |=>
			(state_q == S_RDWAIT) && (count_q == $past(count_q) - CNT_BITS'(1)))
		else $error("pop with entries left did not wait for memory read");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !in_pop && !is_full) |=>
			(count_q == $past(count_q) + CNT_BITS'(1)))
		else $error("accepted push did not grow the stack");
`endif

endmodule
